[rtl/core/time_triggered_task_scheduler_macros.svh]
// Assertion macros for the time-triggered task scheduler.
// Every macro samples on aclk and is switched off while aresetn is low.
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_MACROS_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_MACROS_SVH

// Check that a condition holds at every clock edge.
`define TTS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a consequence holds in the same cycle as its cause.
`define TTS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequence holds in the cycle after its cause.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tts_pkg.sv]
// Shared types and constants of the time-triggered task scheduler.
// No dependencies; tts_div, the scheduler top level and the testbench import it.
`default_nettype none

package tts_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int TICK_MS     = 10;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    // Reciprocal for the millisecond to tick conversion: floor((2^32 - 1) / TICK_MS).
    localparam logic [31:0] TICK_DIV   = 32'(TICK_MS);
    localparam logic [31:0] TICK_RECIP = 32'(64'hFFFF_FFFF / 64'(TICK_MS));

    localparam logic [7:0] RUNS_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_DISPATCH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ADD_ACK    = 2'd0,
        KIND_REMOVE_ACK = 2'd1,
        KIND_DUE        = 2'd2,
        KIND_NONE       = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_DISPATCH,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] countdown;
        logic [31:0] period;
        logic [7:0]  runs;
    } slot_entry_t;

endpackage

`default_nettype wire

[rtl/core/tts_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/tts_div.sv]
// Three-stage divider by the constant TICK_MS (reciprocal multiply plus one correction).
// Depends on tts_pkg.
`default_nettype none

module tts_div
    import tts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [31:0] dividend,
    output logic      [31:0] quotient
);

    logic [31:0] x1_reg;
    logic [63:0] prod1_reg;
    logic [31:0] x2_reg;
    logic [31:0] q0_2_reg;
    logic [31:0] qd2_reg;
    logic [31:0] quot_reg;

    logic [31:0] q0;
    logic [31:0] rem;

    assign q0  = prod1_reg[63:32];
    assign rem = x2_reg - qd2_reg;

    always_ff @(posedge aclk) begin
        // Estimate: at most one below the true quotient.
        x1_reg    <= dividend;
        prod1_reg <= 64'(dividend) * 64'(TICK_RECIP);
        // Back-multiply the estimate; it never exceeds the dividend.
        x2_reg    <= x1_reg;
        q0_2_reg  <= q0;
        qd2_reg   <= 32'(q0 * TICK_DIV);
        // Correct by one where the remainder is still a whole tick.
        quot_reg  <= (rem >= TICK_DIV) ? q0_2_reg + 32'd1 : q0_2_reg;
    end

    assign quotient = quot_reg;

endmodule

`default_nettype wire

[rtl/core/time_triggered_task_scheduler.sv]
// Time-triggered task scheduler. A table of MAX_TASKS slots (handle, countdown in ticks,
// period in ticks, pending-run count) sits in one synchronous RAM; per-slot occupied and
// due flags sit in flip-flops, so reset frees the whole table at once and a free slot
// reads as all zero without any clearing pass. One beat is taken at a time. An add
// converts delay and period to ticks through the three-stage divider and gives one ack
// beat. A remove gives one ack beat. A tick walks every slot: it reads one slot and writes
// back the one before it on every cycle through the single RAM port pair. A dispatch walks
// the slots up to the last due slot and gives one result beat for each due slot (at most
// 16), holding while the result side stalls; with nothing due it gives a single "nothing
// due" beat. Results leave through an output register, so a waiting beat never blocks the
// walk until the next one is ready.
// Depends on tts_pkg, tts_ram, tts_div and the macros header.
`default_nettype none

`include "time_triggered_task_scheduler_macros.svh"

module time_triggered_task_scheduler
    import tts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [31:0] s_task_handle,
    input  wire logic [31:0] s_delay_ms,
    input  wire logic [31:0] s_period_ms,
    input  wire logic [3:0]  s_target_slot,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [3:0]       m_slot_number,
    output logic [31:0]      m_due_handle,
    output logic             m_success,
    output logic             m_last_of_run
);

    // Add sequence: cycle in which each divider result shows up.
    localparam logic [1:0] ADD_DELAY_Q  = 2'd2;
    localparam logic [1:0] ADD_PERIOD_Q = 2'd3;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic [RES_CNT_W-1:0]   nres_reg, nres_next;
    logic [MAX_TASKS-1:0]   occ_reg, occ_next;
    logic [MAX_TASKS-1:0]   due_reg, due_next;

    logic [31:0]            handle_cap_reg, handle_cap_next;
    logic [31:0]            period_cap_reg, period_cap_next;
    logic [31:0]            delay_q_reg, delay_q_next;
    logic [SLOT_W-1:0]      slot_cap_reg, slot_cap_next;
    kind_t                  res_kind_reg, res_kind_next;
    logic [3:0]             res_slot_reg, res_slot_next;
    logic                   res_ok_reg, res_ok_next;

    logic                   m_valid_reg, m_valid_next;
    kind_t                  m_result_kind_reg, m_result_kind_next;
    logic [3:0]             m_slot_number_reg, m_slot_number_next;
    logic [31:0]            m_due_handle_reg, m_due_handle_next;
    logic                   m_success_reg, m_success_next;
    logic                   m_last_of_run_reg, m_last_of_run_next;

    // ------------------------------------------------------------------
    // Slot RAM and divider
    // ------------------------------------------------------------------
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    slot_entry_t            ram_wdata;
    logic [SLOT_W-1:0]      ram_raddr;
    slot_entry_t            ram_rdata;

    logic [31:0]            div_x;
    logic [31:0]            div_q;

    tts_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    tts_div u_tick_div (
        .aclk     (aclk),
        .dividend (div_x),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic                   accept;
    logic                   out_free;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic                   add_ok;
    logic [SLOT_W-1:0]      tgt_idx;
    logic                   tgt_ok;
    slot_entry_t            ent;
    slot_entry_t            tick_ent;
    slot_entry_t            disp_ent;
    logic                   due_above;
    logic                   disp_last;
    logic                   idx_wrap;
    logic [SLOT_W-1:0]      idx_inc;
    logic                   due_beat;
    logic                   tick_accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    // The output register may take a new beat when empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;

    // First free slot, lowest index wins.
    always_comb begin
        free_slot = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign free_found = ~&occ_reg;
    assign add_ok     = (s_task_handle != '0) && free_found;
    assign tgt_idx    = SLOT_W'(s_target_slot);
    assign tgt_ok     = (int'(s_target_slot) < MAX_TASKS) && occ_reg[tgt_idx];

    // A free slot reads as all zero whatever the RAM holds.
    assign ent = occ_reg[idx_reg] ? ram_rdata : '0;

    always_comb begin
        tick_ent = ent;
        if (ent.countdown == '0) begin
            if (ent.runs != RUNS_MAX) begin
                tick_ent.runs = ent.runs + 8'd1;
            end
            if (ent.period != '0) begin
                tick_ent.countdown = ent.period;
            end
        end else begin
            tick_ent.countdown = ent.countdown - 32'd1;
        end
    end

    always_comb begin
        disp_ent      = ent;
        disp_ent.runs = ent.runs - 8'd1;
    end

    // Any due slot beyond the current one decides whether this beat ends the run.
    always_comb begin
        due_above = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (due_reg[i] && (SLOT_W'(i) > idx_reg)) begin
                due_above = 1'b1;
            end
        end
    end

    assign disp_last = !due_above || (nres_reg == RES_CNT_W'(MAX_RESULTS - 1));
    assign idx_wrap  = (idx_reg == SLOT_W'(MAX_TASKS - 1));
    assign idx_inc   = idx_wrap ? '0 : idx_reg + SLOT_W'(1);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode_t'(s_mode))
                        MODE_ADD:      state_next = add_ok ? ST_ADD : ST_RESP;
                        MODE_REMOVE:   state_next = ST_RESP;
                        MODE_TICK:     state_next = ST_TICK;
                        MODE_DISPATCH: state_next = (|due_reg) ? ST_DISPATCH : ST_RESP;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (cnt_reg == ADD_PERIOD_Q) begin
                    state_next = ST_RESP;
                end
            end
            ST_TICK: begin
                if (idx_wrap) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DISPATCH: begin
                if (due_reg[idx_reg]) begin
                    if (out_free && disp_last) begin
                        state_next = ST_IDLE;
                    end
                end else if (idx_wrap) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        idx_next           = idx_reg;
        cnt_next           = cnt_reg;
        nres_next          = nres_reg;
        occ_next           = occ_reg;
        due_next           = due_reg;
        handle_cap_next    = handle_cap_reg;
        period_cap_next    = period_cap_reg;
        delay_q_next       = delay_q_reg;
        slot_cap_next      = slot_cap_reg;
        res_kind_next      = res_kind_reg;
        res_slot_next      = res_slot_reg;
        res_ok_next        = res_ok_reg;

        m_valid_next       = m_valid_reg && !m_ready;
        m_result_kind_next = m_result_kind_reg;
        m_slot_number_next = m_slot_number_reg;
        m_due_handle_next  = m_due_handle_reg;
        m_success_next     = m_success_reg;
        m_last_of_run_next = m_last_of_run_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ent;
        ram_raddr = idx_reg;
        div_x     = period_cap_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // Prime the walk: slot 0 is read on the accepting edge.
                ram_raddr = '0;
                idx_next  = '0;
                cnt_next  = '0;
                nres_next = '0;
                div_x     = s_delay_ms;
                if (accept) begin
                    handle_cap_next = s_task_handle;
                    period_cap_next = s_period_ms;
                    slot_cap_next   = free_slot;
                    unique case (mode_t'(s_mode))
                        MODE_ADD: begin
                            res_kind_next = KIND_ADD_ACK;
                            res_slot_next = add_ok ? 4'(free_slot) : 4'd0;
                            res_ok_next   = add_ok;
                        end
                        MODE_REMOVE: begin
                            res_kind_next = KIND_REMOVE_ACK;
                            res_slot_next = s_target_slot;
                            res_ok_next   = tgt_ok;
                            if (tgt_ok) begin
                                occ_next[tgt_idx] = 1'b0;
                                due_next[tgt_idx] = 1'b0;
                            end
                        end
                        MODE_TICK: begin
                        end
                        MODE_DISPATCH: begin
                            res_kind_next = KIND_NONE;
                            res_slot_next = 4'd0;
                            res_ok_next   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == ADD_DELAY_Q) begin
                    delay_q_next = div_q;
                end
                if (cnt_reg == ADD_PERIOD_Q) begin
                    ram_we                = 1'b1;
                    ram_waddr             = slot_cap_reg;
                    ram_wdata.handle      = handle_cap_reg;
                    ram_wdata.countdown   = delay_q_reg;
                    ram_wdata.period      = div_q;
                    ram_wdata.runs        = 8'd0;
                    occ_next[slot_cap_reg] = 1'b1;
                    due_next[slot_cap_reg] = 1'b0;
                end
            end
            ST_TICK: begin
                // Write back slot idx while slot idx+1 is read.
                ram_we    = occ_reg[idx_reg];
                ram_wdata = tick_ent;
                if (occ_reg[idx_reg] && (ent.countdown == '0)) begin
                    due_next[idx_reg] = 1'b1;
                end
                idx_next  = idx_inc;
                ram_raddr = idx_inc;
            end
            ST_DISPATCH: begin
                if (due_reg[idx_reg]) begin
                    if (out_free) begin
                        m_valid_next       = 1'b1;
                        m_result_kind_next = KIND_DUE;
                        m_slot_number_next = 4'(idx_reg);
                        m_due_handle_next  = ent.handle;
                        m_success_next     = 1'b0;
                        m_last_of_run_next = disp_last;
                        ram_we             = 1'b1;
                        ram_wdata          = disp_ent;
                        // Drop a one-shot task once it has run.
                        if (ent.period == '0) begin
                            occ_next[idx_reg] = 1'b0;
                            due_next[idx_reg] = 1'b0;
                        end else begin
                            due_next[idx_reg] = (disp_ent.runs != '0);
                        end
                        nres_next = nres_reg + RES_CNT_W'(1);
                        idx_next  = idx_inc;
                        ram_raddr = idx_inc;
                    end else begin
                        // Hold: re-read the same slot until the beat can leave.
                        ram_raddr = idx_reg;
                    end
                end else begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_result_kind_next = res_kind_reg;
                    m_slot_number_next = res_slot_reg;
                    m_due_handle_next  = '0;
                    m_success_next     = res_ok_reg;
                    m_last_of_run_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            nres_reg    <= '0;
            occ_reg     <= '0;
            due_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            nres_reg    <= nres_next;
            occ_reg     <= occ_next;
            due_reg     <= due_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        handle_cap_reg    <= handle_cap_next;
        period_cap_reg    <= period_cap_next;
        delay_q_reg       <= delay_q_next;
        slot_cap_reg      <= slot_cap_next;
        res_kind_reg      <= res_kind_next;
        res_slot_reg      <= res_slot_next;
        res_ok_reg        <= res_ok_next;
        m_result_kind_reg <= m_result_kind_next;
        m_slot_number_reg <= m_slot_number_next;
        m_due_handle_reg  <= m_due_handle_next;
        m_success_reg     <= m_success_next;
        m_last_of_run_reg <= m_last_of_run_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_result_kind_reg;
    assign m_slot_number = m_slot_number_reg;
    assign m_due_handle  = m_due_handle_reg;
    assign m_success     = m_success_reg;
    assign m_last_of_run = m_last_of_run_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    assign due_beat    = m_valid_reg && (m_result_kind_reg == KIND_DUE);
    assign tick_accept = accept && (s_mode == MODE_TICK);

    `TTS_ASSERT_ALWAYS(a_due_only_on_occupied, (due_reg & ~occ_reg) == '0, "due on a free slot")
    `TTS_ASSERT_IMPLIES(a_due_handle_nonzero, due_beat, m_due_handle_reg != '0, "zero due handle")
    `TTS_ASSERT_ALWAYS(a_result_cap, nres_reg <= RES_CNT_W'(MAX_RESULTS), "result cap exceeded")
    `TTS_ASSERT_NEXT(a_tick_starts_walk, tick_accept, state_reg == ST_TICK, "tick walk missed")

endmodule

`default_nettype wire

[test/tb_time_triggered_task_scheduler.sv]
// Self-checking testbench for the time-triggered task scheduler: a directed table
// followed by random command beats, results checked against an in-bench slot table or typed-in results.
// Depends on tts_pkg and the time_triggered_task_scheduler top level.
module tb_time_triggered_task_scheduler;
    import tts_pkg::*;

    // Generous bound on the whole run; the slowest legal run stays far below it.
    localparam int CYCLE_LIMIT = 600000;
    // Quiet cycles after the last awaited beat: one full tick walk and then some.
    localparam int DRAIN_CYCLES = 2 * MAX_TASKS + 8;
    localparam int RANDOM_BEATS = 90;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] handle;
        logic [31:0] delay;
        logic [31:0] period;
        logic [3:0]  target;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic [31:0] handle;
        logic        success;
        logic        last;
    } beat_t;

    // One line of the directed table: a command, how often to repeat it, whether
    // handle and target step up with each repeat, and an optional typed-in result.
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] reps;
        logic        bump;
        logic        typed;
        beat_t       want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [31:0] s_task_handle;
    logic [31:0] s_delay_ms;
    logic [31:0] s_period_ms;
    logic [3:0]  s_target_slot;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [3:0]  m_slot_number;
    logic [31:0] m_due_handle;
    logic        m_success;
    logic        m_last_of_run;

    // Shadow copy of the slot table.
    logic [31:0] slot_handle [MAX_TASKS];
    logic [31:0] slot_count  [MAX_TASKS];
    logic [31:0] slot_period [MAX_TASKS];
    logic [7:0]  slot_runs   [MAX_TASKS];

    beat_t     awaited_beats [$];
    plan_row_t plan [$];
    int        mismatches  = 0;
    int        cycle_count = 0;
    bit        s_calm = 1'b0;
    bit        m_calm = 1'b0;

    time_triggered_task_scheduler uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_task_handle (s_task_handle),
        .s_delay_ms    (s_delay_ms),
        .s_period_ms   (s_period_ms),
        .s_target_slot (s_target_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_slot_number (m_slot_number),
        .m_due_handle  (m_due_handle),
        .m_success     (m_success),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic beat_t mk_beat(kind_t kind, logic [3:0] slot, logic [31:0] handle,
                                      logic success, logic last);
        beat_t b;
        b.kind    = kind;
        b.slot    = slot;
        b.handle  = handle;
        b.success = success;
        b.last    = last;
        return b;
    endfunction

    function automatic plan_row_t mk_row(mode_t mode, logic [31:0] handle, logic [31:0] delay,
                                         logic [31:0] period, logic [3:0] target,
                                         int reps, bit bump, bit typed, beat_t want);
        plan_row_t r;
        r.cmd.mode   = mode;
        r.cmd.handle = handle;
        r.cmd.delay  = delay;
        r.cmd.period = period;
        r.cmd.target = target;
        r.reps       = 16'(reps);
        r.bump       = bump;
        r.typed      = typed;
        r.want       = want;
        return r;
    endfunction

    // Mostly a random wait; now and then flip into a calm stretch
    // with no waiting at all, and back out again.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
        mismatches++;
    endtask

    // Apply one accepted command to the shadow table and, when keep is set,
    // queue the result beats it gives.
    task automatic step_scheduler(input cmd_t c, input bit keep);
        bit found;
        int last_due;
        int n_due;
        found    = 1'b0;
        last_due = -1;
        n_due    = 0;
        case (c.mode)
            MODE_ADD: begin
                // A zero handle would mark the slot free, so treat it like a full table.
                if (c.handle != 32'd0) begin
                    for (int s = 0; s < MAX_TASKS; s++) begin
                        if (!found && slot_handle[s] == 32'd0) begin
                            found          = 1'b1;
                            slot_handle[s] = c.handle;
                            slot_count[s]  = c.delay / 32'(TICK_MS);
                            slot_period[s] = c.period / 32'(TICK_MS);
                            slot_runs[s]   = 8'd0;
                            if (keep)
                                awaited_beats.push_back(
                                    mk_beat(KIND_ADD_ACK, s[3:0], 32'd0, 1'b1, 1'b1));
                        end
                    end
                end
                if (!found && keep)
                    awaited_beats.push_back(mk_beat(KIND_ADD_ACK, 4'd0, 32'd0, 1'b0, 1'b1));
            end
            MODE_REMOVE: begin
                if (int'(c.target) < MAX_TASKS && slot_handle[c.target] != 32'd0) begin
                    found                  = 1'b1;
                    slot_handle[c.target]  = 32'd0;
                    slot_count[c.target]   = 32'd0;
                    slot_period[c.target]  = 32'd0;
                    slot_runs[c.target]    = 8'd0;
                end
                if (keep)
                    awaited_beats.push_back(
                        mk_beat(KIND_REMOVE_ACK, c.target, 32'd0, found, 1'b1));
            end
            MODE_TICK: begin
                for (int s = 0; s < MAX_TASKS; s++) begin
                    if (slot_handle[s] != 32'd0) begin
                        if (slot_count[s] == 32'd0) begin
                            // Saturate the run count; reload only periodic tasks, so an
                            // undispatched one-shot keeps gaining runs.
                            if (slot_runs[s] < RUNS_MAX)
                                slot_runs[s] = slot_runs[s] + 8'd1;
                            if (slot_period[s] != 32'd0)
                                slot_count[s] = slot_period[s];
                        end else begin
                            slot_count[s] = slot_count[s] - 32'd1;
                        end
                    end
                end
            end
            default: begin
                // Find the last due slot within the result cap so its beat carries
                // the last flag; due slots beyond the cap keep their runs.
                for (int s = 0; s < MAX_TASKS; s++) begin
                    if (slot_runs[s] != 8'd0 && n_due < MAX_RESULTS) begin
                        last_due = s;
                        n_due++;
                    end
                end
                if (last_due < 0) begin
                    if (keep)
                        awaited_beats.push_back(
                            mk_beat(KIND_NONE, 4'd0, 32'd0, 1'b0, 1'b1));
                end else begin
                    for (int s = 0; s <= last_due; s++) begin
                        if (slot_runs[s] != 8'd0) begin
                            if (keep)
                                awaited_beats.push_back(mk_beat(KIND_DUE, s[3:0],
                                    slot_handle[s], 1'b0, s == last_due));
                            slot_runs[s] = slot_runs[s] - 8'd1;
                            if (slot_period[s] == 32'd0) begin
                                slot_handle[s] = 32'd0;
                                slot_count[s]  = 32'd0;
                                slot_runs[s]   = 8'd0;
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    // Drive one command beat at the falling edge and hold it until accepted.
    // Valid is only lowered when a gap is drawn, so back-to-back beats never
    // see valid dropped and raised in the same step.
    task automatic send_command(input cmd_t c, input bit typed, input beat_t want);
        int gap;
        gap = draw_gap(s_calm);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_mode        <= c.mode;
        s_task_handle <= c.handle;
        s_delay_ms    <= c.delay;
        s_period_ms   <= c.period;
        s_target_slot <= c.target;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        step_scheduler(c, !typed);
        if (typed)
            awaited_beats.push_back(want);
    endtask

    // Random command with well-formed content most of the time: small delays and
    // periods so tasks actually fall due, with full-range values and zero handles mixed in.
    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        pick     = $urandom_range(0, 99);
        c.handle = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom);
        c.target = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 4))
            0:       c.delay = 32'($urandom);
            1:       c.delay = 32'($urandom_range(0, 9));
            default: c.delay = 32'($urandom_range(0, 80));
        endcase
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: c.period = 32'd0;
            5, 6, 7:       c.period = 32'($urandom_range(1, 9));
            8, 9, 10:      c.period = 32'($urandom);
            default:       c.period = 32'($urandom_range(10, 60));
        endcase
        if (pick < 30)
            c.mode = MODE_ADD;
        else if (pick < 42)
            c.mode = MODE_REMOVE;
        else if (pick < 80)
            c.mode = MODE_TICK;
        else
            c.mode = MODE_DISPATCH;
        return c;
    endfunction

    // Result side: wait a drawn number of cycles before each beat, then take it.
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            gap = draw_gap(m_calm);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Check every accepted result beat against the oldest awaited one.
    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_beats.size() == 0) begin
                report_mismatch("beat with nothing awaited", 32'(m_result_kind), 32'd0);
            end else begin
                want = awaited_beats.pop_front();
                if (m_result_kind !== want.kind)
                    report_mismatch("result_kind", 32'(m_result_kind), 32'(want.kind));
                if (m_slot_number !== want.slot)
                    report_mismatch("slot_number", 32'(m_slot_number), 32'(want.slot));
                if (m_due_handle !== want.handle)
                    report_mismatch("due_handle", m_due_handle, want.handle);
                if (m_success !== want.success)
                    report_mismatch("success", 32'(m_success), 32'(want.success));
                if (m_last_of_run !== want.last)
                    report_mismatch("last_of_run", 32'(m_last_of_run), 32'(want.last));
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[time_triggered_task_scheduler] ERROR");
            $finish;
        end
    end

    initial begin
        cmd_t  c;
        beat_t nil;
        nil           = '0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = MODE_ADD;
        s_task_handle = 32'd0;
        s_delay_ms    = 32'd0;
        s_period_ms   = 32'd0;
        s_target_slot = 4'd0;
        for (int s = 0; s < MAX_TASKS; s++) begin
            slot_handle[s] = 32'd0;
            slot_count[s]  = 32'd0;
            slot_period[s] = 32'd0;
            slot_runs[s]   = 8'd0;
        end

        // Directed table. Typed-in results only where they are plain to see.
        // Empty table after reset: nothing due, removing a free slot fails.
        plan.push_back(mk_row(MODE_DISPATCH, 0, 0, 0, 0, 1, 0, 1,
                              mk_beat(KIND_NONE, 4'd0, 32'd0, 1'b0, 1'b1)));
        plan.push_back(mk_row(MODE_REMOVE, 0, 0, 0, 4'd15, 1, 0, 1,
                              mk_beat(KIND_REMOVE_ACK, 4'd15, 32'd0, 1'b0, 1'b1)));
        // Zero handle is turned away like a full table.
        plan.push_back(mk_row(MODE_ADD, 32'd0, 32'd50, 32'd50, 0, 1, 0, 1,
                              mk_beat(KIND_ADD_ACK, 4'd0, 32'd0, 1'b0, 1'b1)));
        // Field extremes: one-shot with no delay, maximum delay and period, and a
        // period below one tick that degrades to one-shot.
        plan.push_back(mk_row(MODE_ADD, 32'hFFFF_FFFF, 32'd0, 32'd0, 0, 1, 0, 1,
                              mk_beat(KIND_ADD_ACK, 4'd0, 32'd0, 1'b1, 1'b1)));
        plan.push_back(mk_row(MODE_ADD, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 1,
                              mk_beat(KIND_ADD_ACK, 4'd1, 32'd0, 1'b1, 1'b1)));
        plan.push_back(mk_row(MODE_ADD, 32'h8000_0000, 32'd9, 32'd9, 0, 1, 0, 1,
                              mk_beat(KIND_ADD_ACK, 4'd2, 32'd0, 1'b1, 1'b1)));
        // Undispatched one-shots keep piling up runs; dispatch frees them.
        plan.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 3, 0, 0, nil));
        plan.push_back(mk_row(MODE_DISPATCH, 0, 0, 0, 0, 2, 0, 0, nil));
        plan.push_back(mk_row(MODE_REMOVE, 0, 0, 0, 4'd1, 1, 0, 1,
                              mk_beat(KIND_REMOVE_ACK, 4'd1, 32'd0, 1'b1, 1'b1)));
        // Clear every slot, then fill the table and overflow it.
        plan.push_back(mk_row(MODE_REMOVE, 0, 0, 0, 4'd0, MAX_TASKS, 1, 0, nil));
        plan.push_back(mk_row(MODE_ADD, 32'hA5A5_0001, 32'd19, 32'd20, 0, MAX_TASKS, 1, 0,
                              nil));
        plan.push_back(mk_row(MODE_ADD, 32'h5A5A_5A5A, 32'd0, 32'd0, 0, 1, 0, 1,
                              mk_beat(KIND_ADD_ACK, 4'd0, 32'd0, 1'b0, 1'b1)));
        // Every slot due at once: the widest dispatch.
        plan.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 2, 0, 0, nil));
        plan.push_back(mk_row(MODE_DISPATCH, 0, 0, 0, 0, 1, 0, 0, nil));
        plan.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 1, 0, 0, nil));
        plan.push_back(mk_row(MODE_DISPATCH, 0, 0, 0, 0, 1, 0, 0, nil));
        // Free the top slot and reuse it.
        plan.push_back(mk_row(MODE_REMOVE, 0, 0, 0, 4'd15, 1, 0, 1,
                              mk_beat(KIND_REMOVE_ACK, 4'd15, 32'd0, 1'b1, 1'b1)));
        plan.push_back(mk_row(MODE_ADD, 32'h0000_BEEF, 32'd55, 32'd15, 0, 1, 0, 1,
                              mk_beat(KIND_ADD_ACK, 4'd15, 32'd0, 1'b1, 1'b1)));
        plan.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 6, 0, 0, nil));
        plan.push_back(mk_row(MODE_DISPATCH, 0, 0, 0, 0, 1, 0, 0, nil));

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            for (int r = 0; r < int'(plan[i].reps); r++) begin
                c = plan[i].cmd;
                if (plan[i].bump) begin
                    c.handle = c.handle + 32'(r);
                    c.target = c.target + 4'(r);
                end
                send_command(c, plan[i].typed, plan[i].want);
            end
        end

        for (int n = 0; n < RANDOM_BEATS; n++)
            send_command(random_command(), 1'b0, nil);

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain: wait for every awaited beat, then give any stray beat time to show.
        while (awaited_beats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("[time_triggered_task_scheduler] OK");
        else
            $display("[time_triggered_task_scheduler] ERROR");
        $finish;
    end

endmodule

[time_triggered_task_scheduler.f]
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_ram.sv
rtl/core/tts_div.sv
rtl/core/time_triggered_task_scheduler.sv
test/tb_time_triggered_task_scheduler.sv
